>>> rtl/ismc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ismc_pkg: shared types and constants for the idle sniff mode controller
// Holds the command and request codes, link mode codes, register map and the
// structs passed between the register file, the core and the top level.
// ----------------------------------------------------------------------------
package ismc_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned APB_ADDR_W      = 5;
  localparam int unsigned APB_DATA_W      = 32;
  localparam int unsigned LIMIT_W         = 32;
  localparam int unsigned HANDLE_W        = 12;
  localparam int unsigned IVAL_W          = 16;
  localparam int unsigned S_TDATA_W       = 16;
  localparam int unsigned M_TDATA_W       = 24;

  localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RST = 32'd1000;

  typedef enum logic [1:0] {
    CMD_TICK        = 2'd0,
    CMD_ACTIVITY    = 2'd1,
    CMD_MODE_CHANGE = 2'd2,
    CMD_RESULT      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_ENTER = 2'd1,
    REQ_EXIT  = 2'd2
  } req_kind_t;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_ACTIVE = 2'd0;
  localparam mode_t MODE_SNIFF  = 2'd2;

  typedef enum logic [2:0] {
    REG_IDLE_LIMIT    = 3'd0,
    REG_OWN_HANDLE    = 3'd1,
    REG_SNIFF_MAX     = 3'd2,
    REG_SNIFF_MIN     = 3'd3,
    REG_SNIFF_ATTEMPT = 3'd4,
    REG_SNIFF_TIMEOUT = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [LIMIT_W-1:0]  idle_limit;
    logic [HANDLE_W-1:0] own_handle;
  } cfg_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [HANDLE_W-1:0] handle;
    logic                ok;
    mode_t               mode;
  } item_t;

  typedef struct packed {
    logic                pending;
    mode_t               mode;
    logic [HANDLE_W-1:0] handle;
    req_kind_t           kind;
  } result_t;

endpackage

>>> rtl/ismc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ismc_cfg_regs: configuration register file
// APB-style slave holding the idle limit, own handle and sniff request values.
// ----------------------------------------------------------------------------
module ismc_cfg_regs
  import ismc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [LIMIT_W-1:0]  idle_limit;
  logic [HANDLE_W-1:0] own_handle;
  logic [IVAL_W-1:0]   sniff_ival_max;
  logic [IVAL_W-1:0]   sniff_ival_min;
  logic [IVAL_W-1:0]   sniff_attempt_count;
  logic [IVAL_W-1:0]   sniff_timeout_value;
  reg_idx_t            idx;
  logic                wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_limit          <= IDLE_LIMIT_RST;
      own_handle          <= '0;
      sniff_ival_max      <= '0;
      sniff_ival_min      <= '0;
      sniff_attempt_count <= '0;
      sniff_timeout_value <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_IDLE_LIMIT:    idle_limit          <= pwdata[LIMIT_W-1:0];
        REG_OWN_HANDLE:    own_handle          <= pwdata[HANDLE_W-1:0];
        REG_SNIFF_MAX:     sniff_ival_max      <= pwdata[IVAL_W-1:0];
        REG_SNIFF_MIN:     sniff_ival_min      <= pwdata[IVAL_W-1:0];
        REG_SNIFF_ATTEMPT: sniff_attempt_count <= pwdata[IVAL_W-1:0];
        REG_SNIFF_TIMEOUT: sniff_timeout_value <= pwdata[IVAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_IDLE_LIMIT:    prdata = idle_limit;
      REG_OWN_HANDLE:    prdata = {{(APB_DATA_W-HANDLE_W){1'b0}}, own_handle};
      REG_SNIFF_MAX:     prdata = {{(APB_DATA_W-IVAL_W){1'b0}}, sniff_ival_max};
      REG_SNIFF_MIN:     prdata = {{(APB_DATA_W-IVAL_W){1'b0}}, sniff_ival_min};
      REG_SNIFF_ATTEMPT: prdata = {{(APB_DATA_W-IVAL_W){1'b0}}, sniff_attempt_count};
      REG_SNIFF_TIMEOUT: prdata = {{(APB_DATA_W-IVAL_W){1'b0}}, sniff_timeout_value};
      default:           prdata = '0;
    endcase
  end

  assign cfg.idle_limit = idle_limit;
  assign cfg.own_handle = own_handle;

endmodule

>>> rtl/ismc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ismc_core: link power policy state and decision logic
// Keeps idle count, armed flag, link mode and pending flag; works out one
// result per word and commits the new state when the word moves on.
// ----------------------------------------------------------------------------
module ismc_core
  import ismc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    commit,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

  logic [COUNT_WIDTH-1:0] idle_count, idle_count_next, count_inc;
  logic                   timer_armed, timer_armed_next;
  mode_t                  link_mode, link_mode_next;
  logic                   pending, pending_next;
  logic [CMP_W-1:0]       count_ext, limit_ext;
  logic                   limit_hit;
  req_kind_t              req;

  // saturating increment, then compare against the limit at a common width
  assign count_inc = (&idle_count) ? idle_count : idle_count + 1'b1;
  assign count_ext = CMP_W'(count_inc);
  assign limit_ext = CMP_W'(cfg.idle_limit);
  assign limit_hit = count_ext >= limit_ext;

  always_comb begin
    idle_count_next  = idle_count;
    timer_armed_next = timer_armed;
    link_mode_next   = link_mode;
    pending_next     = pending;
    req              = REQ_NONE;
    unique case (item.cmd)
      CMD_TICK: begin
        if (timer_armed) begin
          idle_count_next = count_inc;
          if (limit_hit) begin
            idle_count_next = '0;
            if (!pending) begin
              if (link_mode == MODE_SNIFF) begin
                timer_armed_next = 1'b0;
              end else begin
                req          = REQ_ENTER;
                pending_next = 1'b1;
              end
            end
          end
        end
      end
      CMD_ACTIVITY: begin
        idle_count_next = '0;
        if (link_mode != MODE_ACTIVE && !pending) begin
          req          = REQ_EXIT;
          pending_next = 1'b1;
        end
      end
      CMD_MODE_CHANGE: begin
        if (item.handle == cfg.own_handle && item.ok) begin
          pending_next   = 1'b0;
          link_mode_next = item.mode;
          if (item.mode != MODE_SNIFF) begin
            timer_armed_next = 1'b1;
            idle_count_next  = '0;
          end
        end
      end
      CMD_RESULT: begin
        if (!item.ok) begin
          pending_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_count  <= '0;
      timer_armed <= 1'b1;
      link_mode   <= MODE_ACTIVE;
      pending     <= 1'b0;
    end else if (commit) begin
      idle_count  <= idle_count_next;
      timer_armed <= timer_armed_next;
      link_mode   <= link_mode_next;
      pending     <= pending_next;
    end
  end

  assign result.kind    = req;
  assign result.handle  = (req != REQ_NONE) ? cfg.own_handle : '0;
  assign result.mode    = link_mode_next;
  assign result.pending = pending_next;

  a_req_sets_pending: assert property (@(posedge clk) disable iff (rst)
    (commit && req != REQ_NONE) |=> pending)
    else $error("request issued without pending flag");

  a_disarmed_count_holds: assert property (@(posedge clk) disable iff (rst)
    (commit && item.cmd == CMD_TICK && !timer_armed) |=> $stable(idle_count))
    else $error("idle count moved on a disarmed tick");

  a_disarm_in_sniff: assert property (@(posedge clk) disable iff (rst)
    $fell(timer_armed) |-> (link_mode == MODE_SNIFF))
    else $error("timer disarmed outside sniff mode");

endmodule

>>> rtl/idle_sniff_mode_controller.sv
`timescale 1ns / 1ps
// an accepted word is held in the input register; its result goes into the result register, which drives m_tdata
// throughput: one word per cycle, held only by m_tready backpressure
// the rate is set by the combinational decision between input and result register
// reset (rst, synchronous): idle_count 0, timer armed, mode active, nothing pending
// reset: idle_limit 1000, all other registers 0, both stages empty
// ----------------------------------------------------------------------------
// idle_sniff_mode_controller: idle-driven sniff policy for one connection
// Input register, decision core and result register, with an APB register file.
// ----------------------------------------------------------------------------
module idle_sniff_mode_controller
  import ismc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [11:0] event_handle, [12] event_ok, [14:13] event_mode, [15] zero
  input  logic [S_TDATA_W-1:0]  s_tdata,
  // [1:0] command
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [1:0] request_kind, [13:2] request_handle, [15:14] link mode,
  // [16] pending_flag, [23:17] zero
  output logic [M_TDATA_W-1:0]  m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  logic    advance;
  result_t result;
  result_t out_res;

  ismc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input word moves on whenever the result register is free or being drained
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.cmd    <= cmd_t'(s_tuser);
      in_item.handle <= s_tdata[HANDLE_W-1:0];
      in_item.ok     <= s_tdata[HANDLE_W];
      in_item.mode   <= s_tdata[HANDLE_W+2:HANDLE_W+1];
    end
  end

  ismc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .item   (in_item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= result;
    end
  end

  assign m_tdata = {7'd0, out_res.pending, out_res.mode, out_res.handle, out_res.kind};

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the idle sniff mode controller
// Words are fed to the slave stream from a queue and every accepted word is run
// through a local model of the sniff policy. Each result word on the master
// stream is checked field by field against the oldest prediction. Registers
// are rewritten over APB between phases while the block is quiet, and the
// phases vary the idle limit, the handle and the idling on both streams.
// ----------------------------------------------------------------------------
module testbench;
  import ismc_pkg::*;

  localparam mode_t MODE_HOLD     = 2'd1;
  localparam mode_t MODE_RESERVED = 2'd3;
  localparam logic [2:0] SPARE_IDX_LO = 3'd6;
  localparam logic [2:0] SPARE_IDX_HI = 3'd7;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic [1:0]            s_tuser = CMD_TICK;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  idle_sniff_mode_controller DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // words waiting to be sent, and the word currently offered
  item_t   pending_words[$];
  item_t   offered_word;
  result_t expected_results[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatch_count = 0;
  int items_queued = 0;
  int stall_cycles = 0;

  // local copy of the policy state and the registers it depends on
  logic [COUNT_WIDTH_DEF-1:0] idle_count = '0;
  logic                       timer_armed = 1'b1;
  mode_t                      link_mode = MODE_ACTIVE;
  logic                       link_pending = 1'b0;
  logic [LIMIT_W-1:0]         limit_cfg = IDLE_LIMIT_RST;
  logic [HANDLE_W-1:0]        handle_cfg = '0;

  function automatic result_t predict_sniff_policy(item_t it);
    result_t   r;
    req_kind_t req;
    req = REQ_NONE;
    case (it.cmd)
      CMD_TICK: begin
        if (timer_armed) begin
          if (idle_count != '1) idle_count = idle_count + 1'b1;
          if (idle_count >= limit_cfg) begin
            idle_count = '0;
            if (!link_pending) begin
              if (link_mode == MODE_SNIFF) begin
                timer_armed = 1'b0;
              end else begin
                req = REQ_ENTER;
                link_pending = 1'b1;
              end
            end
          end
        end
      end
      CMD_ACTIVITY: begin
        idle_count = '0;
        if (link_mode != MODE_ACTIVE && !link_pending) begin
          req = REQ_EXIT;
          link_pending = 1'b1;
        end
      end
      CMD_MODE_CHANGE: begin
        if (it.handle == handle_cfg && it.ok) begin
          link_pending = 1'b0;
          link_mode = it.mode;
          if (link_mode != MODE_SNIFF) begin
            timer_armed = 1'b1;
            idle_count = '0;
          end
        end
      end
      default: begin
        if (!it.ok) link_pending = 1'b0;
      end
    endcase
    r.kind = req;
    r.handle = (req != REQ_NONE) ? handle_cfg : '0;
    r.mode = link_mode;
    r.pending = link_pending;
    return r;
  endfunction

  // driver: offer queued words, predict each one as it is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_results.push_back(predict_sniff_policy(offered_word));
      if (!s_tvalid || s_tready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_word = pending_words.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {1'b0, offered_word.mode, offered_word.ok, offered_word.handle};
          s_tuser <= offered_word.cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure and in-order checking of result words
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[16:0]);
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result word %h", m_tdata);
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.handle !== want.handle ||
              got.mode !== want.mode || got.pending !== want.pending) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("result mismatch: kind %0d/%0d handle %h/%h mode %0d/%0d pending %b/%b",
                       want.kind, got.kind, want.handle, got.handle,
                       want.mode, got.mode, want.pending, got.pending);
          end
        end
      end
    end
  end

  // watchdog on cycles without any stream or register traffic
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic queue_word(cmd_t cmd, logic [HANDLE_W-1:0] handle, logic ok, mode_t mode);
    item_t it;
    it.cmd = cmd;
    it.handle = handle;
    it.ok = ok;
    it.mode = mode;
    pending_words.push_back(it);
    items_queued++;
  endtask

  // a word of the given kind with random handle, ok and mode fields
  task automatic queue_loose(cmd_t cmd);
    queue_word(cmd, 12'($urandom_range(4095)), 1'($urandom_range(1)),
               mode_t'($urandom_range(3)));
  endtask

  task automatic queue_ticks(int count);
    repeat (count) queue_loose(CMD_TICK);
  endtask

  // idle run into sniff, then activity and a return to some other mode
  task automatic queue_sniff_session();
    int span;
    span = (limit_cfg > 8) ? 4 : int'(limit_cfg);
    queue_ticks(int'($urandom_range(span + 1)));
    if ($urandom_range(3) == 0) queue_loose(CMD_RESULT);
    queue_word(CMD_MODE_CHANGE,
               ($urandom_range(9) == 0) ? 12'($urandom_range(4095)) : handle_cfg,
               $urandom_range(9) != 0,
               ($urandom_range(9) < 7) ? MODE_SNIFF : mode_t'($urandom_range(3)));
    queue_ticks(int'($urandom_range(span + 2)));
    queue_loose(CMD_ACTIVITY);
    if ($urandom_range(3) == 0) queue_loose(CMD_ACTIVITY);
    if ($urandom_range(4) == 0) queue_word(CMD_RESULT, 12'($urandom_range(4095)), 1'b0,
                                           mode_t'($urandom_range(3)));
    queue_word(CMD_MODE_CHANGE, handle_cfg, $urandom_range(9) != 0,
               ($urandom_range(9) < 7) ? MODE_ACTIVE : mode_t'($urandom_range(3)));
  endtask

  task automatic queue_random_words(int count);
    int start;
    start = items_queued;
    while (items_queued - start < count) begin
      if ($urandom_range(4) == 0)
        queue_word(cmd_t'($urandom_range(3)),
                   $urandom_range(1) ? handle_cfg : 12'($urandom_range(4095)),
                   1'($urandom_range(1)), mode_t'($urandom_range(3)));
      else
        queue_sniff_session();
    end
  endtask

  // sampled on the falling edge so the driver and monitor have settled
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(logic [2:0] idx, logic [APB_DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_IDLE_LIMIT: limit_cfg = value;
      REG_OWN_HANDLE: handle_cfg = value[HANDLE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [31:0] limit, logic [31:0] handle, logic [31:0] sniff);
    write_register(REG_IDLE_LIMIT, limit);
    write_register(REG_OWN_HANDLE, handle);
    write_register(REG_SNIFF_MAX, sniff);
    write_register(REG_SNIFF_MIN, ~sniff);
    write_register(REG_SNIFF_ATTEMPT, sniff);
    write_register(REG_SNIFF_TIMEOUT, ~sniff);
  endtask

  task automatic run_phase(int send_pct, int stall, logic [31:0] limit, logic [31:0] handle,
                           logic [31:0] sniff, int count);
    send_idle_pct = send_pct;
    stall_pct = stall;
    configure(limit, handle, sniff);
    queue_random_words(count / 2);
    // sender holds off until the block has answered everything
    wait_quiet();
    queue_random_words(count - count / 2);
    wait_quiet();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 16;
    stall_pct = 16;
    // upper bits of the handle word are junk and must be dropped
    configure(32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_word(CMD_TICK, 12'h000, 1'b0, MODE_ACTIVE);
    queue_word(CMD_TICK, 12'hFFF, 1'b1, MODE_RESERVED);
    queue_loose(CMD_TICK);
    queue_loose(CMD_TICK);
    queue_loose(CMD_ACTIVITY);
    queue_word(CMD_RESULT, 12'h000, 1'b1, MODE_SNIFF);
    queue_word(CMD_RESULT, 12'hFFF, 1'b0, MODE_HOLD);
    // foreign handle, then a failed event for our own handle
    queue_word(CMD_MODE_CHANGE, 12'h000, 1'b1, MODE_SNIFF);
    queue_word(CMD_MODE_CHANGE, 12'hFFF, 1'b0, MODE_SNIFF);
    queue_word(CMD_MODE_CHANGE, 12'hFFF, 1'b1, MODE_SNIFF);
    queue_ticks(3);
    queue_loose(CMD_ACTIVITY);
    queue_loose(CMD_ACTIVITY);
    queue_word(CMD_MODE_CHANGE, 12'hFFF, 1'b1, MODE_HOLD);
    queue_ticks(2);
    queue_word(CMD_MODE_CHANGE, 12'hFFF, 1'b1, MODE_RESERVED);
    queue_loose(CMD_ACTIVITY);
    queue_word(CMD_MODE_CHANGE, 12'hFFF, 1'b1, MODE_ACTIVE);
    wait_quiet();

    // zero limit: every armed tick reaches it
    write_register(REG_IDLE_LIMIT, 32'd0);
    queue_loose(CMD_TICK);
    queue_word(CMD_MODE_CHANGE, 12'hFFF, 1'b1, MODE_SNIFF);
    queue_loose(CMD_TICK);
    queue_loose(CMD_ACTIVITY);
    wait_quiet();

    run_phase(0, 0, 32'd3, 32'd0, 32'h0000_0000, 260);
    run_phase(88, 0, 32'd1, 32'h0000_0FFF, 32'h0000_FFFF, 260);
    run_phase(0, 88, 32'd0, $urandom(), $urandom(), 260);
    write_register(SPARE_IDX_LO, $urandom());
    write_register(SPARE_IDX_HI, $urandom());
    run_phase(16, 16, $urandom_range(8, 2), $urandom(), $urandom(), 240);
    run_phase(16, 16, 32'hFFFF_FFFF, $urandom(), $urandom(), 40);

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
